### hw/rtl/cmphd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmphd_pkg
// Shared types and constants of the compass heading core: fixed-point widths,
// the arctangent table in fractions of a turn, and the queue item formats.
// ----------------------------------------------------------------------------
package cmphd_pkg;

  localparam int IN_W        = 16;
  localparam int HEAD_W      = 16;
  localparam int GUARD_BITS  = 24;
  localparam int ANGLE_GUARD = 4;
  localparam int ATAN_LEN    = 24;
  // pre-rotated axis value, one bit wider than the reading
  localparam int PRE_W       = IN_W + 1;
  // two bits of headroom cover the cordic gain
  localparam int DATA_W      = PRE_W + GUARD_BITS + 2;
  localparam int MID_DEPTH   = 2;
  localparam int OUT_DEPTH   = 2;

  // atan(2^-i) / (2*pi) * 2^32, rounded to nearest
  localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [PRE_W-1:0] a;
    logic signed [PRE_W-1:0] b;
    logic                    half;
    logic                    zero;
  } pre_t;

  typedef struct packed {
    logic [HEAD_W-1:0] heading;
    logic              zero;
  } res_t;

  // table entry rounded half up to acc_bits bits
  function automatic logic [31:0] atan_step(input int idx, input int acc_bits);
    logic [32:0] sum;
    sum = {1'b0, ATAN_TURNS[idx]} + (33'd1 << (31 - acc_bits));
    return 32'(sum >> (32 - acc_bits));
  endfunction

endpackage
`default_nettype wire

### hw/rtl/cmphd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmphd_fifo
// Small register queue with push/pop handshakes, used between the front and
// the cordic pipeline and in front of the result port.
// ----------------------------------------------------------------------------
module cmphd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rd_data_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign empty_o   = (count_q == '0);
  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

### hw/rtl/cmphd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmphd_front
// Classifies an incoming sample: flags the zero vector and folds the lower
// half plane onto the upper one, noting the half turn it stands for.
// ----------------------------------------------------------------------------
module cmphd_front (
  input  wire logic signed [cmphd_pkg::IN_W-1:0] field_x_i,
  input  wire logic signed [cmphd_pkg::IN_W-1:0] field_y_i,
  output cmphd_pkg::pre_t                         item_o
);

  import cmphd_pkg::*;

  logic signed [PRE_W-1:0] x_ext, y_ext;

  assign x_ext = PRE_W'(field_x_i);
  assign y_ext = PRE_W'(field_y_i);

  always_comb begin
    item_o.zero = (field_x_i == '0) && (field_y_i == '0);
    item_o.half = field_y_i[IN_W-1];
    if (item_o.half) begin
      item_o.a = -y_ext;
      item_o.b = -x_ext;
    end else begin
      item_o.a = y_ext;
      item_o.b = x_ext;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/cmphd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmphd_back
// Vectoring cordic pipeline, one rotation per stage, followed by rounding of
// the turn accumulator to the heading. The whole pipe holds while the result
// queue is full.
// ----------------------------------------------------------------------------
module cmphd_back #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cmphd_pkg::pre_t item_i,
  input  wire logic            item_valid_i,
  output logic                 item_pop_o,
  input  wire logic            res_full_i,
  output logic                 res_push_o,
  output cmphd_pkg::res_t      res_o
);

  import cmphd_pkg::*;

  localparam int ACC_W = ANGLE_BITS + ANGLE_GUARD;
  localparam int NSTG  = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int EXT_W = DATA_W - PRE_W - GUARD_BITS;

  logic                     en;
  logic signed [DATA_W-1:0] a_q [NSTG];
  logic signed [DATA_W-1:0] a_d [NSTG];
  logic signed [DATA_W-1:0] b_q [NSTG];
  logic signed [DATA_W-1:0] b_d [NSTG];
  logic [ACC_W-1:0]         z_q [NSTG];
  logic [ACC_W-1:0]         z_d [NSTG];
  logic [NSTG-1:0]          zero_q, zero_d;
  logic [NSTG-1:0]          vld_q, vld_d;
  logic [ACC_W-1:0]         z_round;
  logic [ANGLE_BITS-1:0]    r_angle;
  logic [HEAD_W-1:0]        head;

  assign en         = ~res_full_i;
  assign item_pop_o = en & item_valid_i;

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    localparam logic [ACC_W-1:0] TSTEP = ACC_W'(atan_step(i, ACC_W));
    logic signed [DATA_W-1:0] a_in, b_in;
    logic [ACC_W-1:0]         z_in;
    logic                     zero_in, vld_in;

    if (i == 0) begin : g_first
      assign a_in    = $signed({{EXT_W{item_i.a[PRE_W-1]}}, item_i.a, {GUARD_BITS{1'b0}}});
      assign b_in    = $signed({{EXT_W{item_i.b[PRE_W-1]}}, item_i.b, {GUARD_BITS{1'b0}}});
      assign z_in    = item_i.half ? {1'b1, {(ACC_W-1){1'b0}}} : '0;
      assign zero_in = item_i.zero;
      assign vld_in  = item_valid_i;
    end else begin : g_next
      assign a_in    = a_q[i-1];
      assign b_in    = b_q[i-1];
      assign z_in    = z_q[i-1];
      assign zero_in = zero_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    // b on the axis counts as non-negative
    always_comb begin
      if (b_in[DATA_W-1]) begin
        a_d[i] = a_in - (b_in >>> i);
        b_d[i] = b_in + (a_in >>> i);
        z_d[i] = z_in - TSTEP;
      end else begin
        a_d[i] = a_in + (b_in >>> i);
        b_d[i] = b_in - (a_in >>> i);
        z_d[i] = z_in + TSTEP;
      end
      zero_d[i] = zero_in;
      vld_d[i]  = vld_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NSTG; k++) begin
        a_q[k] <= a_d[k];
        b_q[k] <= b_d[k];
        z_q[k] <= z_d[k];
      end
      zero_q <= zero_d;
    end
  end

  // round off the guard bits, a full turn wraps to zero
  assign z_round = z_q[NSTG-1] + ACC_W'(1 << (ANGLE_GUARD - 1));
  assign r_angle = z_round[ACC_W-1:ANGLE_GUARD];

  if (ANGLE_BITS >= HEAD_W) begin : g_head_trunc
    assign head = r_angle[ANGLE_BITS-1 -: HEAD_W];
  end else begin : g_head_pad
    assign head = {r_angle, {(HEAD_W-ANGLE_BITS){1'b0}}};
  end

  assign res_push_o    = en & vld_q[NSTG-1];
  assign res_o.heading = zero_q[NSTG-1] ? '0 : head;
  assign res_o.zero    = zero_q[NSTG-1];

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |=> vld_q[0])
    else $error("popped item did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NSTG-1] && !en) |=> (vld_q[NSTG-1] && $stable(z_q[NSTG-1])))
    else $error("last stage changed while stalled");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

endmodule
`default_nettype wire

### hw/rtl/compass_heading_from_field_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// compass_heading_from_field_core
// Heading of a magnetometer (x, y) pair from +y toward +x, as a fraction of a
// turn, by a pipelined vectoring cordic.
// ----------------------------------------------------------------------------
// channel  | handshake      | beat fields
// ---------+----------------+--------------------------------
// sample   | push / full    | field_x_i, field_y_i
// result   | empty / pop    | heading_o, zero_vector_o
//
// one sample per cycle sustained while the result queue is not full; a
// sample passes the input queue, the rotation stages and the result queue
// reset clears the queues and the stage valid bits, nothing else needs it
// a full result queue holds the whole cordic pipe; the two-entry input queue
// then fills and raises full
// ----------------------------------------------------------------------------
module compass_heading_from_field_core #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic signed [cmphd_pkg::IN_W-1:0]   field_x_i,
  input  wire logic signed [cmphd_pkg::IN_W-1:0]   field_y_i,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic             [cmphd_pkg::HEAD_W-1:0] heading_o,
  output logic                                     zero_vector_o
);

  import cmphd_pkg::*;

  pre_t front_item, mid_item;
  res_t back_res, out_res;
  logic mid_empty, mid_pop;
  logic res_full, res_push;

  cmphd_front u_front (
    .field_x_i (field_x_i),
    .field_y_i (field_y_i),
    .item_o    (front_item)
  );

  cmphd_fifo #(
    .WIDTH ($bits(pre_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (front_item),
    .pop_i     (mid_pop),
    .rd_data_o (mid_item),
    .empty_o   (mid_empty),
    .full_o    (full)
  );

  cmphd_back #(
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (mid_item),
    .item_valid_i (~mid_empty),
    .item_pop_o   (mid_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (back_res)
  );

  cmphd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (res_push),
    .wr_data_i (back_res),
    .pop_i     (pop),
    .rd_data_o (out_res),
    .empty_o   (empty),
    .full_o    (res_full)
  );

  assign heading_o     = out_res.heading;
  assign zero_vector_o = out_res.zero;

endmodule
`default_nettype wire

### tb/sv/tb_compass_heading_from_field_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_compass_heading_from_field_core
// Self-checking bench for the compass heading core. Magnetometer (x, y) pairs
// go in through the push side in random bursts. Each accepted pair is run
// through a bit-exact vectoring cordic model, and the result is queued. The
// result side pops on a changing stall pattern. Every heading and zero flag
// is checked against the oldest queued result.
// ----------------------------------------------------------------------------
module tb_compass_heading_from_field_core;

  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD         = 24;
  localparam int ANG_GUARD     = 4;
  localparam int ACC_W         = ANGLE_BITS + ANG_GUARD;
  localparam int TBL_LEN       = 24;
  localparam int N_RANDOM      = 1850;
  localparam int TAIL_CYCLES   = 4 * (CORDIC_STAGES + 1);
  localparam int CYCLE_LIMIT   = 600000;

  // atan(2^-i) as a fraction of a turn, scaled by 2^32
  localparam logic [31:0] ATAN_FRAC [TBL_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct {
    logic signed [cmphd_pkg::IN_W-1:0] x;
    logic signed [cmphd_pkg::IN_W-1:0] y;
    bit                                drain;
  } sample_t;

  typedef struct {
    logic [cmphd_pkg::HEAD_W-1:0] heading;
    logic                         zero;
  } heading_beat_t;

  logic                                clk_i         = 1'b0;
  logic                                rst_ni        = 1'b0;
  logic                                push          = 1'b0;
  logic                                pop           = 1'b0;
  logic signed [cmphd_pkg::IN_W-1:0]   field_x_i     = '0;
  logic signed [cmphd_pkg::IN_W-1:0]   field_y_i     = '0;
  logic                                full;
  logic                                empty;
  logic        [cmphd_pkg::HEAD_W-1:0] heading_o;
  logic                                zero_vector_o;

  sample_t       sample_q[$];
  heading_beat_t pending_headings[$];

  int n_directed  = 0;
  int n_drains    = 0;
  int n_sent      = 0;
  int n_zero      = 0;
  int n_results   = 0;
  int n_mismatch  = 0;
  int cycle_cnt   = 0;
  int burst_left  = 8;
  int gap_left    = 0;
  int rx_mode     = 0;
  int rx_left     = 0;

  compass_heading_from_field_core #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .field_x_i    (field_x_i),
    .field_y_i    (field_y_i),
    .empty        (empty),
    .pop          (pop),
    .heading_o    (heading_o),
    .zero_vector_o(zero_vector_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // vectoring cordic on (a, b) = (y, x), angle accumulated in turns
  function automatic heading_beat_t cordic_heading(logic signed [15:0] fx,
                                                   logic signed [15:0] fy);
    heading_beat_t     res;
    longint            a, b, na, nb;
    longint unsigned   rnd;
    logic [ACC_W-1:0]  z;
    logic [ACC_W-1:0]  step;
    logic [31:0]       ang;
    int                i, n_stages;
    res.zero    = (fx == 0) && (fy == 0);
    res.heading = '0;
    if (!res.zero) begin
      a = longint'(fy) <<< GUARD;
      b = longint'(fx) <<< GUARD;
      z = '0;
      // negative y: rotate by half a turn first
      if (a < 0) begin
        a = -a;
        b = -b;
        z[ACC_W-1] = 1'b1;
      end
      n_stages = (CORDIC_STAGES > TBL_LEN) ? TBL_LEN : CORDIC_STAGES;
      for (i = 0; i < n_stages; i++) begin
        rnd  = (longint'(ATAN_FRAC[i]) + (64'd1 << (31 - ACC_W))) >> (32 - ACC_W);
        step = rnd[ACC_W-1:0];
        if (b >= 0) begin
          na = a + (b >>> i);
          nb = b - (a >>> i);
          z  = z + step;
        end else begin
          na = a - (b >>> i);
          nb = b + (a >>> i);
          z  = z - step;
        end
        a = na;
        b = nb;
      end
      // round off the guard bits, a full turn wraps to zero
      ang = ((32'(z) + (32'd1 << (ANG_GUARD - 1))) >> ANG_GUARD) &
            ((32'd1 << ANGLE_BITS) - 32'd1);
      if (ANGLE_BITS >= 16) begin
        ang = ang >> (ANGLE_BITS - 16);
      end else begin
        ang = ang << (16 - ANGLE_BITS);
      end
      res.heading = ang[15:0];
    end
    return res;
  endfunction

  task automatic add_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                            input bit drain);
    sample_t s;
    s.x     = x;
    s.y     = y;
    s.drain = drain;
    sample_q.push_back(s);
  endtask

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh8001;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      default: return 16'sh7FFF;
    endcase
  endfunction

  task automatic add_random_sample(input bit drain);
    logic signed [15:0] x, y;
    x = 16'($urandom_range(0, 65535));
    y = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      5: begin
        x = 16'($urandom_range(0, 8)) - 16'sd4;
        y = 16'($urandom_range(0, 8)) - 16'sd4;
      end
      6: x = 16'($urandom_range(0, 6)) - 16'sd3;   // close to the y axis
      7: y = 16'($urandom_range(0, 6)) - 16'sd3;   // close to the x axis
      8: begin
        y = ($urandom_range(0, 1) != 0) ? x : -x;
        y = y + 16'($urandom_range(0, 2)) - 16'sd1;
      end
      9: begin
        x = pick_extreme();
        y = pick_extreme();
      end
      default: ;
    endcase
    add_sample(x, y, drain);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t s;
    bit      go;
    if (!rst_ni) begin
      push      <= 1'b0;
      field_x_i <= '0;
      field_y_i <= '0;
    end else begin
      if (push && !full) begin
        s = sample_q.pop_front();
        pending_headings.push_back(cordic_heading(s.x, s.y));
        n_sent++;
        if (s.x == 0 && s.y == 0) n_zero++;
      end
      // an unaccepted beat stays on the bus as it is
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left--;
          go = 1'b0;
        end else if (sample_q.size() == 0) begin
          go = 1'b0;
        end else if (sample_q[0].drain && pending_headings.size() != 0) begin
          go = 1'b0;
        end else begin
          go = 1'b1;
        end
        if (go) begin
          field_x_i <= sample_q[0].x;
          field_y_i <= sample_q[0].y;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 5))
              0, 1, 2: gap_left = 0;
              3, 4:    gap_left = $urandom_range(1, 6);
              default: gap_left = $urandom_range(7, 30);
            endcase
          end
        end
        push <= go;
      end
    end
  end

  // receiver: stall pattern changes mode after a random stretch
  always @(posedge clk_i or negedge rst_ni) begin
    heading_beat_t want;
    logic          nxt_pop;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_results++;
        if (pending_headings.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("unexpected result beat: heading %0d zero_vector %0b",
                     heading_o, zero_vector_o);
          end
        end else begin
          want = pending_headings.pop_front();
          if (heading_o !== want.heading || zero_vector_o !== want.zero) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("result %0d mismatch: exp heading %0d zero %0b, got heading %0d zero %0b",
                       n_results, want.heading, want.zero, heading_o, zero_vector_o);
            end
          end
        end
      end
      if (rx_left <= 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(64, 300);
      end
      rx_left--;
      case (rx_mode)
        0:       nxt_pop = 1'b1;
        1:       nxt_pop = ($urandom_range(0, 1) != 0);
        2:       nxt_pop = ($urandom_range(0, 7) == 0);
        default: nxt_pop = (rx_left % 24) < 6;   // long regular stalls
      endcase
      pop <= nxt_pop;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_cnt, pending_headings.size());
      $display("tb_compass_heading_from_field_core: FAIL");
      $finish;
    end
  end

  initial begin
    int i;
    // zero vector, the four axes and their extremes
    add_sample(16'sd0, 16'sd0, 1'b0);
    add_sample(16'sd0, 16'sd1, 1'b0);
    add_sample(16'sd1, 16'sd0, 1'b0);
    add_sample(16'sd0, -16'sd1, 1'b0);
    add_sample(-16'sd1, 16'sd0, 1'b0);
    add_sample(16'sd0, 16'sh7FFF, 1'b0);
    add_sample(16'sh7FFF, 16'sd0, 1'b0);
    add_sample(16'sd0, 16'sh8000, 1'b0);
    add_sample(16'sh8000, 16'sd0, 1'b0);
    // diagonals and near-diagonals; on the exact ones b lands on zero after the first stage
    add_sample(16'sd1, 16'sd1, 1'b0);
    add_sample(-16'sd1, -16'sd1, 1'b0);
    add_sample(-16'sd1, 16'sd1, 1'b0);
    add_sample(16'sd1, -16'sd1, 1'b0);
    add_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
    add_sample(16'sh8000, 16'sh8000, 1'b0);
    add_sample(16'sh8000, 16'sh7FFF, 1'b0);
    add_sample(16'sh7FFF, 16'sh8000, 1'b0);
    // one step either side of the y axis; just short of a full turn rounds up and wraps to zero
    add_sample(-16'sd1, 16'sh7FFF, 1'b0);
    add_sample(16'sd1, 16'sh7FFF, 1'b0);
    add_sample(-16'sd1, 16'sh8000, 1'b0);
    add_sample(16'sd1, 16'sh8000, 1'b0);
    add_sample(16'sd0, 16'sd0, 1'b0);
    n_directed = sample_q.size();
    for (i = 0; i < N_RANDOM; i++) begin
      if (i % 500 == 0) n_drains++;
      add_random_sample(i % 500 == 0);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (sample_q.size() == 0);
    wait (pending_headings.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d samples (%0d directed, %0d zero vectors), %0d results checked",
             n_sent, n_directed, n_zero, n_results);
    $display("%0d pauses to drain the pipe, %0d mismatches, %0d cycles",
             n_drains, n_mismatch, cycle_cnt);
    if (n_mismatch == 0 && pending_headings.size() == 0) begin
      $display("tb_compass_heading_from_field_core: PASS");
    end else begin
      $display("tb_compass_heading_from_field_core: FAIL");
    end
    $finish;
  end

endmodule
